// ===== sv/bt_ffa_pkg.sv =====
// Shared types, codes and tag helper for the boundary-tag first-fit allocator.
package bt_ffa_pkg;

	localparam int POS_W = 8;
	localparam int CNT_W = 5;

	localparam logic [2:0] ACT_MALLOC = 3'd0;
	localparam logic [2:0] ACT_FREE   = 3'd1;
	localparam logic [2:0] ACT_WRITE  = 3'd2;
	localparam logic [2:0] ACT_READ   = 3'd3;
	localparam logic [2:0] ACT_LIST   = 3'd4;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_IGNORE = 2'd2;

	localparam logic [POS_W-1:0] MIN_SPLIT = 8'd3;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] payload_size;
		logic [6:0] block_handle;
		logic [5:0] byte_index;
		logic [7:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] handle;
		logic [5:0] listed_payload;
		logic       listed_allocated;
		logic [7:0] read_data;
		logic       last;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RD_P,
		OP_RD_IDX,
		OP_WR_IDX,
		OP_ADV,
		OP_M_HDR,
		OP_M_FTR,
		OP_M_RHDR,
		OP_M_RFTR,
		OP_F_SET,
		OP_RD_R,
		OP_F_R,
		OP_RD_L,
		OP_RD_LH,
		OP_F_L,
		OP_CLR_INIT,
		OP_CLR,
		OP_F_WS,
		OP_F_WE
	} op_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_NO_FIT,
		RES_IGNORE,
		RES_MALLOC,
		RES_READ,
		RES_LIST
	} res_t;

	typedef struct packed {
		op_t  op;
		logic emit;
		res_t res;
	} ctl_t;

	typedef struct packed {
		logic       item_valid;
		logic [2:0] action;
		logic       out_free;
		logic       blk_ok;
		logic       fit;
		logic       more;
		logic       split;
		logic       list_last;
		logic       handle_bad;
		logic       hdr_alloc;
		logic       right_exists;
		logic       p_nonzero;
		logic       l_ok;
		logic       clr_more;
	} sts_t;

	function automatic logic [7:0] tag(input logic [POS_W-1:0] size, input logic alloc);
		return {size[6:0], alloc};
	endfunction

endpackage

// ===== sv/bt_ffa_ctrl.sv =====
// Sequencer for malloc, free, byte access and list walks.
module bt_ffa_ctrl
	import bt_ffa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	typedef enum logic [20:0] {
		S_IDLE    = 21'd1 << 0,
		S_M_RD    = 21'd1 << 1,
		S_M_CHK   = 21'd1 << 2,
		S_M_FTR   = 21'd1 << 3,
		S_M_RHDR  = 21'd1 << 4,
		S_M_RFTR  = 21'd1 << 5,
		S_F_RD    = 21'd1 << 6,
		S_F_CHK   = 21'd1 << 7,
		S_F_R0    = 21'd1 << 8,
		S_F_RCHK  = 21'd1 << 9,
		S_F_L0    = 21'd1 << 10,
		S_F_LCHK  = 21'd1 << 11,
		S_F_LHCHK = 21'd1 << 12,
		S_F_CINIT = 21'd1 << 13,
		S_F_CLR   = 21'd1 << 14,
		S_F_WE    = 21'd1 << 15,
		S_B_WR    = 21'd1 << 16,
		S_B_RD    = 21'd1 << 17,
		S_L_RD    = 21'd1 << 18,
		S_L_CHK   = 21'd1 << 19,
		S_EMIT    = 21'd1 << 20
	} state_t;

	state_t state_q, state_d;
	res_t   res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_ZERO;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		ctl.op   = OP_NONE;
		ctl.emit = 1'b0;
		ctl.res  = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (sts.item_valid) begin
					ctl.op = OP_LOAD;
					case (sts.action)
						ACT_MALLOC: state_d = S_M_RD;
						ACT_FREE:   state_d = S_F_RD;
						ACT_WRITE:  state_d = S_B_WR;
						ACT_READ:   state_d = S_B_RD;
						ACT_LIST:   state_d = S_L_RD;
						default: begin
							res_d   = RES_ZERO;
							state_d = S_EMIT;
						end
					endcase
				end
			end
			S_M_RD: begin
				ctl.op  = OP_RD_P;
				state_d = S_M_CHK;
			end
			S_M_CHK: begin
				if (!sts.blk_ok) begin
					res_d   = RES_NO_FIT;
					state_d = S_EMIT;
				end else if (sts.fit) begin
					ctl.op  = OP_M_HDR;
					state_d = S_M_FTR;
				end else begin
					ctl.op = OP_ADV;
					if (sts.more) begin
						state_d = S_M_RD;
					end else begin
						res_d   = RES_NO_FIT;
						state_d = S_EMIT;
					end
				end
			end
			S_M_FTR: begin
				ctl.op = OP_M_FTR;
				res_d  = RES_MALLOC;
				state_d = sts.split ? S_M_RHDR : S_EMIT;
			end
			S_M_RHDR: begin
				ctl.op  = OP_M_RHDR;
				state_d = S_M_RFTR;
			end
			S_M_RFTR: begin
				ctl.op  = OP_M_RFTR;
				state_d = S_EMIT;
			end
			S_F_RD: begin
				if (sts.handle_bad) begin
					res_d   = RES_IGNORE;
					state_d = S_EMIT;
				end else begin
					ctl.op  = OP_RD_P;
					state_d = S_F_CHK;
				end
			end
			S_F_CHK: begin
				if (!sts.hdr_alloc || !sts.blk_ok) begin
					res_d   = RES_IGNORE;
					state_d = S_EMIT;
				end else begin
					ctl.op  = OP_F_SET;
					state_d = S_F_R0;
				end
			end
			S_F_R0: begin
				if (sts.right_exists) begin
					ctl.op  = OP_RD_R;
					state_d = S_F_RCHK;
				end else begin
					state_d = S_F_L0;
				end
			end
			S_F_RCHK: begin
				ctl.op  = OP_F_R;
				state_d = S_F_L0;
			end
			S_F_L0: begin
				if (sts.p_nonzero) begin
					ctl.op  = OP_RD_L;
					state_d = S_F_LCHK;
				end else begin
					state_d = S_F_CINIT;
				end
			end
			S_F_LCHK: begin
				if (sts.l_ok) begin
					ctl.op  = OP_RD_LH;
					state_d = S_F_LHCHK;
				end else begin
					state_d = S_F_CINIT;
				end
			end
			S_F_LHCHK: begin
				ctl.op  = OP_F_L;
				state_d = S_F_CINIT;
			end
			S_F_CINIT: begin
				ctl.op  = OP_CLR_INIT;
				state_d = S_F_CLR;
			end
			S_F_CLR: begin
				if (sts.clr_more) begin
					ctl.op = OP_CLR;
				end else begin
					ctl.op  = OP_F_WS;
					state_d = S_F_WE;
				end
			end
			S_F_WE: begin
				ctl.op  = OP_F_WE;
				res_d   = RES_ZERO;
				state_d = S_EMIT;
			end
			S_B_WR: begin
				ctl.op  = OP_WR_IDX;
				res_d   = RES_ZERO;
				state_d = S_EMIT;
			end
			S_B_RD: begin
				ctl.op  = OP_RD_IDX;
				res_d   = RES_READ;
				state_d = S_EMIT;
			end
			S_L_RD: begin
				ctl.op  = OP_RD_P;
				state_d = S_L_CHK;
			end
			S_L_CHK: begin
				ctl.res = RES_LIST;
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					if (!sts.blk_ok || sts.list_last) begin
						state_d = S_IDLE;
					end else begin
						ctl.op  = OP_ADV;
						state_d = S_L_RD;
					end
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/bt_ffa_dp.sv =====
// Heap store, walk registers and result register of the allocator.
module bt_ffa_dp
	import bt_ffa_pkg::*;
#(
	parameter int HEAP_BYTES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_t      ctl,
	input  in_item_t  in_item,
	input  logic      in_valid,
	input  logic      busy,
	input  logic      out_stall,
	output logic      out_valid,
	output out_item_t out_item,
	output sts_t      sts
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam logic [POS_W-1:0] N = POS_W'(HEAP_BYTES);
	localparam logic [7:0] RST_TAG = 8'((HEAP_BYTES * 2) % 256);

	logic [7:0]       mem [HEAP_BYTES];
	logic [HEAP_BYTES-1:0] wvalid_q;
	logic [7:0]       rdata_q;

	logic [5:0]       req_q;
	logic [6:0]       handle_q;
	logic [5:0]       idx_q;
	logic [7:0]       wd_q;
	logic [POS_W-1:0] p_q, s_q, take_q, start_q, end_q, i_q;
	logic [CNT_W-1:0] k_q;
	logic             out_valid_q;
	out_item_t        out_q;
	out_item_t        out_d;

	logic [POS_W-1:0] s_rd, idx_c, addr, take_c, rem_c;
	logic [7:0]       wdata;
	logic             rd_en, wr_en;

	assign s_rd  = {1'b0, rdata_q[7:1]};
	assign idx_c = ({2'b0, idx_q} >= N) ? (N - 8'd1) : {2'b0, idx_q};
	assign rem_c = s_rd - 8'd2 - {2'b0, req_q};
	assign take_c = (rem_c < MIN_SPLIT) ? (s_rd - 8'd2) : {2'b0, req_q};

	always_comb begin
		addr  = p_q;
		wdata = 8'd0;
		rd_en = 1'b0;
		wr_en = 1'b0;
		case (ctl.op)
			OP_RD_P:   rd_en = 1'b1;
			OP_RD_IDX: begin
				rd_en = 1'b1;
				addr  = idx_c;
			end
			OP_WR_IDX: begin
				wr_en = 1'b1;
				addr  = idx_c;
				wdata = wd_q;
			end
			OP_M_HDR: begin
				wr_en = 1'b1;
				wdata = tag(take_c + 8'd2, 1'b1);
			end
			OP_M_FTR: begin
				wr_en = 1'b1;
				addr  = p_q + take_q + 8'd1;
				wdata = tag(take_q + 8'd2, 1'b1);
			end
			OP_M_RHDR: begin
				wr_en = 1'b1;
				addr  = p_q + take_q + 8'd2;
				wdata = tag(s_q - take_q - 8'd2, 1'b0);
			end
			OP_M_RFTR: begin
				wr_en = 1'b1;
				addr  = p_q + s_q - 8'd1;
				wdata = tag(s_q - take_q - 8'd2, 1'b0);
			end
			OP_RD_R: begin
				rd_en = 1'b1;
				addr  = end_q + 8'd1;
			end
			OP_RD_L: begin
				rd_en = 1'b1;
				addr  = p_q - 8'd1;
			end
			OP_RD_LH: begin
				rd_en = 1'b1;
				addr  = p_q - s_rd;
			end
			OP_CLR: begin
				wr_en = 1'b1;
				addr  = i_q;
			end
			OP_F_WS: begin
				wr_en = 1'b1;
				addr  = start_q;
				wdata = tag(end_q - start_q + 8'd1, 1'b0);
			end
			OP_F_WE: begin
				wr_en = 1'b1;
				addr  = end_q;
				wdata = tag(end_q - start_q + 8'd1, 1'b0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr[AW-1:0]] <= wdata;
		end
		if (rd_en) begin
			if (wvalid_q[addr[AW-1:0]]) begin
				rdata_q <= mem[addr[AW-1:0]];
			end else if (addr[AW-1:0] == '0 || addr[AW-1:0] == AW'(HEAP_BYTES - 1)) begin
				rdata_q <= RST_TAG;
			end else begin
				rdata_q <= 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (wr_en) begin
			wvalid_q[addr[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				req_q    <= in_item.payload_size;
				handle_q <= in_item.block_handle;
				idx_q    <= in_item.byte_index;
				wd_q     <= in_item.write_data;
				k_q      <= '0;
				p_q      <= (in_item.action == ACT_FREE) ?
					({1'b0, in_item.block_handle} - 8'd1) : 8'd0;
			end
			OP_ADV: begin
				p_q <= p_q + s_rd;
				k_q <= k_q + 1'b1;
			end
			OP_M_HDR: begin
				s_q    <= s_rd;
				take_q <= take_c;
			end
			OP_F_SET: begin
				s_q     <= s_rd;
				start_q <= p_q;
				end_q   <= p_q + s_rd - 8'd1;
			end
			OP_F_R: begin
				if (!rdata_q[0] && s_rd >= 8'd2 && end_q + 8'd1 + s_rd <= N) begin
					end_q <= end_q + s_rd;
				end
			end
			OP_RD_LH: s_q <= s_rd;
			OP_F_L: begin
				if (!rdata_q[0]) begin
					start_q <= p_q - s_q;
				end
			end
			OP_CLR_INIT: i_q <= start_q + 8'd1;
			OP_CLR:      i_q <= i_q + 8'd1;
			default: ;
		endcase
	end

	assign sts.item_valid   = in_valid;
	assign sts.action       = in_item.action;
	assign sts.out_free     = !out_valid_q || !out_stall;
	assign sts.blk_ok       = (s_rd >= 8'd2) && (p_q + s_rd <= N);
	assign sts.fit          = !rdata_q[0] && ((s_rd - 8'd2) >= {2'b0, req_q});
	assign sts.more         = (p_q + s_rd) < N;
	assign sts.split        = take_q < (s_q - 8'd2);
	assign sts.list_last    = ((p_q + s_rd) >= N) || (k_q == '1);
	assign sts.handle_bad   = (handle_q == 7'd0) || ({1'b0, handle_q} > N);
	assign sts.hdr_alloc    = rdata_q[0];
	assign sts.right_exists = (end_q + 8'd1) < N;
	assign sts.p_nonzero    = (p_q != 8'd0);
	assign sts.l_ok         = (s_rd >= 8'd2) && (s_rd <= p_q);
	assign sts.clr_more     = i_q < end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_d      = '0;
		out_d.last = 1'b1;
		case (ctl.res)
			RES_NO_FIT: out_d.status = ST_NO_FIT;
			RES_IGNORE: out_d.status = ST_IGNORE;
			RES_MALLOC: out_d.handle = 7'(p_q + 8'd1);
			RES_READ:   out_d.read_data = rdata_q;
			RES_LIST: begin
				out_d.handle           = 7'(p_q + 8'd1);
				out_d.listed_allocated = rdata_q[0];
				if (sts.blk_ok) begin
					out_d.listed_payload = 6'(s_rd - 8'd2);
					out_d.last           = sts.list_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an unaccepted result");
	a_clr_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_CLR) |-> (i_q > start_q && i_q < end_q && end_q < N))
		else $error("clear outside the coalesced block");
	a_free_span: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_F_WE) |-> (start_q < end_q && end_q < N))
		else $error("coalesced block out of heap");
	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_M_HDR) |-> (p_q + take_c + 8'd2 <= N))
		else $error("allocated block runs past heap");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_LOAD) |-> !busy)
		else $error("item loaded while busy");

endmodule

// ===== sv/boundary_tag_first_fit_allocator.sv =====
// Top level of the boundary-tag first-fit heap allocator.
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid, cmd_stall | cmd_item (in_item_t)
//  rsp     | out       | rsp_valid, rsp_stall | rsp_item (out_item_t)
// One item at a time; cmd_stall is high from acceptance until the last result is loaded.
// Malloc walks blocks first-fit, then tags the block and any split-off remainder.
// Free merges free neighbours and clears the payload bytes; list gives one result per block.
// Byte write and read use the clamped index; all heap access goes through one memory port.
// Reset leaves one free block over the heap; no clearing pass is needed.
// rsp_stall holds the result register; the sequencer waits until it frees up.
module boundary_tag_first_fit_allocator
	import bt_ffa_pkg::*;
#(
	parameter int HEAP_BYTES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  in_item_t  cmd_item,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp_item
);

	ctl_t ctl;
	sts_t sts;
	logic busy;

	assign cmd_stall = busy;

	bt_ffa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.ctl   (ctl),
		.busy  (busy)
	);

	bt_ffa_dp #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_item  (cmd_item),
		.in_valid (cmd_valid),
		.busy     (busy),
		.out_stall(rsp_stall),
		.out_valid(rsp_valid),
		.out_item (rsp_item),
		.sts      (sts)
	);

endmodule

// ===== bench/boundary_tag_first_fit_allocator_test.sv =====
// Testbench for the boundary-tag first-fit allocator, checked against a behavioral heap.
`timescale 1ns / 1ps
module boundary_tag_first_fit_allocator_test;
	import bt_ffa_pkg::*;

	localparam int HEAP = 64;
	localparam int CYCLE_LIMIT = 900000;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	in_item_t cmd_item;
	logic rsp_valid;
	logic rsp_stall;
	out_item_t rsp_item;

	boundary_tag_first_fit_allocator #(.HEAP_BYTES(HEAP)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item)
	);

	logic [7:0] heap_model [HEAP];
	in_item_t pending_cmds [$];
	out_item_t expected_rsps [$];
	int failures = 0;
	int cycle_count = 0;
	bit stimulus_done = 0;
	bit hold_off = 0;
	int burst_left = 0;
	int gap_left = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic out_item_t result(logic [1:0] st, logic [6:0] hd, logic [5:0] pay,
			logic al, logic [7:0] rd, logic lst);
		out_item_t r;
		r.status = st;
		r.handle = hd;
		r.listed_payload = pay;
		r.listed_allocated = al;
		r.read_data = rd;
		r.last = lst;
		return r;
	endfunction

	function automatic logic [7:0] make_tag(int size, logic alloc);
		return {size[6:0], alloc};
	endfunction

	function automatic bit well_formed(int pos, int size);
		return size >= 2 && pos + size <= HEAP;
	endfunction

	function automatic int clamp(logic [5:0] idx);
		return (idx >= HEAP) ? HEAP - 1 : idx;
	endfunction

	task automatic predict_malloc(int req);
		int p;
		int s;
		int take;
		int r;
		int rs;
		p = 0;
		while (p < HEAP) begin
			s = heap_model[p] >> 1;
			if (!well_formed(p, s))
				break;
			if (!heap_model[p][0] && s - 2 >= req) begin
				take = (s - 2 - req < 3) ? s - 2 : req;
				heap_model[p] = make_tag(take + 2, 1'b1);
				heap_model[p + take + 1] = make_tag(take + 2, 1'b1);
				if (take < s - 2) begin
					r = p + take + 2;
					rs = s - take - 2;
					heap_model[r] = make_tag(rs, 1'b0);
					heap_model[r + rs - 1] = make_tag(rs, 1'b0);
				end
				expected_rsps.push_back(result(ST_DONE, 7'(p + 1), 6'd0, 1'b0, 8'd0, 1'b1));
				return;
			end
			p += s;
		end
		expected_rsps.push_back(result(ST_NO_FIT, 7'd0, 6'd0, 1'b0, 8'd0, 1'b1));
	endtask

	task automatic predict_free(int hnd);
		int f;
		int s;
		int ff;
		int lo;
		int hi;
		int rh;
		int rs;
		int ls;
		if (hnd == 0 || hnd > HEAP) begin
			expected_rsps.push_back(result(ST_IGNORE, 7'd0, 6'd0, 1'b0, 8'd0, 1'b1));
			return;
		end
		f = hnd - 1;
		s = heap_model[f] >> 1;
		if (!heap_model[f][0] || !well_formed(f, s)) begin
			expected_rsps.push_back(result(ST_IGNORE, 7'd0, 6'd0, 1'b0, 8'd0, 1'b1));
			return;
		end
		ff = f + s - 1;
		lo = f;
		hi = ff;
		if (ff + 1 < HEAP) begin
			rh = ff + 1;
			rs = heap_model[rh] >> 1;
			if (!heap_model[rh][0] && well_formed(rh, rs))
				hi = rh + rs - 1;
		end
		if (f > 0) begin
			ls = heap_model[f - 1] >> 1;
			if (ls >= 2 && ls <= f && !heap_model[f - ls][0])
				lo = f - ls;
		end
		for (int i = lo + 1; i < hi; i++)
			heap_model[i] = 0;
		heap_model[lo] = make_tag(hi - lo + 1, 1'b0);
		heap_model[hi] = make_tag(hi - lo + 1, 1'b0);
		expected_rsps.push_back(result(ST_DONE, 7'd0, 6'd0, 1'b0, 8'd0, 1'b1));
	endtask

	task automatic predict_list();
		int p;
		int k;
		int s;
		p = 0;
		k = 0;
		while (p < HEAP && k < 32) begin
			s = heap_model[p] >> 1;
			if (!well_formed(p, s)) begin
				expected_rsps.push_back(result(ST_DONE, 7'(p + 1), 6'd0, heap_model[p][0],
					8'd0, 1'b1));
				return;
			end
			expected_rsps.push_back(result(ST_DONE, 7'(p + 1), 6'(s - 2), heap_model[p][0],
				8'd0, (p + s >= HEAP || k == 31)));
			k++;
			p += s;
		end
	endtask

	task automatic predict_heap(in_item_t it);
		case (it.action)
			ACT_MALLOC: predict_malloc(it.payload_size);
			ACT_FREE: predict_free(it.block_handle);
			ACT_WRITE: begin
				heap_model[clamp(it.byte_index)] = it.write_data;
				expected_rsps.push_back(result(ST_DONE, 7'd0, 6'd0, 1'b0, 8'd0, 1'b1));
			end
			ACT_READ: expected_rsps.push_back(result(ST_DONE, 7'd0, 6'd0, 1'b0,
				heap_model[clamp(it.byte_index)], 1'b1));
			ACT_LIST: predict_list();
			default: expected_rsps.push_back(result(ST_DONE, 7'd0, 6'd0, 1'b0, 8'd0, 1'b1));
		endcase
	endtask

	function automatic in_item_t make_cmd(logic [2:0] act, logic [5:0] sz, logic [6:0] hd,
			logic [5:0] idx, logic [7:0] wd);
		in_item_t it;
		it.action = act;
		it.payload_size = sz;
		it.block_handle = hd;
		it.byte_index = idx;
		it.write_data = wd;
		return it;
	endfunction

	function automatic in_item_t random_cmd();
		in_item_t it;
		int pick;
		it = make_cmd(ACT_MALLOC, 6'($urandom), 7'($urandom), 6'($urandom), 8'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it.action = ACT_MALLOC;
			it.payload_size = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, 12));
		end else if (pick < 65) begin
			it.action = ACT_FREE;
			if ($urandom_range(0, 9) == 0)
				it.block_handle = 7'($urandom_range(0, 127));
			else
				it.block_handle = 7'($urandom_range(1, 64));
		end else if (pick < 75) begin
			it.action = ACT_WRITE;
		end else if (pick < 85) begin
			it.action = ACT_READ;
		end else if (pick < 97) begin
			it.action = ACT_LIST;
		end else begin
			it.action = 3'($urandom_range(5, 7));
		end
		return it;
	endfunction

	initial begin
		pending_cmds.push_back(make_cmd(ACT_LIST, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_MALLOC, 63, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_MALLOC, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_MALLOC, 5, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_MALLOC, 10, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_MALLOC, 38, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_LIST, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_FREE, 0, 3, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_FREE, 0, 3, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_FREE, 0, 1, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_FREE, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_FREE, 0, 127, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_FREE, 0, 65, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 63, 8'hFF));
		pending_cmds.push_back(make_cmd(ACT_READ, 0, 0, 63, 0));
		pending_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_FREE, 0, 10, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 0, 8'h01));
		pending_cmds.push_back(make_cmd(ACT_LIST, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_MALLOC, 1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 0, 8'h80));
		pending_cmds.push_back(make_cmd(ACT_LIST, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 0, 8'h7E));
		pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 63, 8'h7E));
		pending_cmds.push_back(make_cmd(3'd5, 0, 0, 0, 0));
		for (int i = 0; i < 316; i++) begin
			if (i == 100) begin
				pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 0, 8'h80));
				pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 63, 8'h80));
				for (int j = 1; j < 63; j++)
					pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 6'(j), 0));
			end
			if (i == 200) begin
				pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 0, 8'h04));
				for (int j = 1; j < 63; j += 2)
					pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 6'(j + 1), 8'h04));
				for (int j = 1; j < 64; j += 2)
					pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 0, 6'(j), 8'h04));
				pending_cmds.push_back(make_cmd(ACT_LIST, 0, 0, 0, 0));
			end
			pending_cmds.push_back(random_cmd());
		end
	end

	initial begin
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 0;
			cmd_item <= '0;
			burst_left <= 0;
			gap_left <= 0;
			for (int i = 0; i < HEAP; i++)
				heap_model[i] = 0;
			heap_model[0] = make_tag(HEAP, 1'b0);
			heap_model[HEAP - 1] = make_tag(HEAP, 1'b0);
		end else begin
			if (cmd_valid && !cmd_stall)
				predict_heap(cmd_item);
			if (cmd_valid && cmd_stall) begin
			end else if (gap_left > 0) begin
				cmd_valid <= 0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() > 0) begin
				cmd_valid <= 1;
				cmd_item <= pending_cmds.pop_front();
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				cmd_valid <= 0;
				stimulus_done <= 1;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_off <= 1;
		repeat (400) @(posedge clk);
		hold_off <= 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected result %p", rsp_item);
					failures++;
				end else begin
					out_item_t e;
					e = expected_rsps.pop_front();
					if (rsp_item.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, rsp_item.status);
						failures++;
					end
					if (rsp_item.handle !== e.handle) begin
						$error("handle expected %0d actual %0d", e.handle, rsp_item.handle);
						failures++;
					end
					if (rsp_item.listed_payload !== e.listed_payload) begin
						$error("listed_payload expected %0d actual %0d", e.listed_payload,
							rsp_item.listed_payload);
						failures++;
					end
					if (rsp_item.listed_allocated !== e.listed_allocated) begin
						$error("listed_allocated expected %0d actual %0d",
							e.listed_allocated, rsp_item.listed_allocated);
						failures++;
					end
					if (rsp_item.read_data !== e.read_data) begin
						$error("read_data expected %0d actual %0d", e.read_data,
							rsp_item.read_data);
						failures++;
					end
					if (rsp_item.last !== e.last) begin
						$error("last expected %0d actual %0d", e.last, rsp_item.last);
						failures++;
					end
				end
			end
			if (hold_off)
				rsp_stall <= 1;
			else if ((cycle_count / 97) % 3 == 0)
				rsp_stall <= 0;
			else
				rsp_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		@(posedge arst_n);
		while (!(stimulus_done && expected_rsps.size() == 0) && cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("boundary_tag_first_fit_allocator_test failed");
			$finish;
		end else begin
			repeat (100) @(posedge clk);
			if (failures == 0 && expected_rsps.size() == 0)
				$display("boundary_tag_first_fit_allocator_test passed");
			else
				$display("boundary_tag_first_fit_allocator_test failed");
			$finish;
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

endmodule

// ===== sim.f =====
sv/bt_ffa_pkg.sv
sv/bt_ffa_ctrl.sv
sv/bt_ffa_dp.sv
sv/boundary_tag_first_fit_allocator.sv
bench/boundary_tag_first_fit_allocator_test.sv
